>>> design/prss_pkg.sv
// Shared types, constants and codes for the phased rate source scheduler.
`default_nettype none
package prss_pkg;

  localparam int PHASE_SLOTS = 16;
  localparam int PTR_W = (PHASE_SLOTS > 1) ? $clog2(PHASE_SLOTS) : 1;
  localparam int CNT_W = ((PTR_W > 4) ? PTR_W : 4) + 1;

  localparam int S_DATA_W = 88;
  localparam int M_DATA_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [1:0] MODE_CONST_PROB = 2'd0;
  localparam logic [1:0] MODE_PHASE_PROB = 2'd1;
  localparam logic [1:0] MODE_CONST_FLOW = 2'd2;
  localparam logic [1:0] MODE_PHASE_FLOW = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_START_TIME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_PROB  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_FLOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_COUNT = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_START,
    ST_ADV,
    ST_VAL
  } state_t;

  typedef struct packed {
    logic [31:0] start_time;
    logic [15:0] period;
    logic [1:0]  source_mode;
    logic [15:0] fixed_probability;
    logic [7:0]  fixed_flow;
    logic [4:0]  phase_count;
  } cfg_t;

  typedef struct packed {
    logic        command;
    logic [31:0] iteration;
    logic [15:0] random_value;
    logic [3:0]  entry_index;
    logic [15:0] entry_duration;
    logic [15:0] entry_value;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
    logic [31:0] start_time;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
    logic ge;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> design/phased_rate_source_scheduler_unit.sv
// Top level: stream ports, configuration registers and unit wiring.
// Sequence: a tick word runs the bit-serial remainder and start compare, then
// the start, phase advance and result states before the output register loads.
// A write word goes straight to the result state, then loads the output register.
// Flow: one word at a time; no new word is taken until the last result is loaded.
// Reset: synchronous; clears run state, pointer, age, output and registers.
`default_nettype none
module phased_rate_source_scheduler_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // iteration[31:0], random_value[47:32], entry_index[51:48],
  // entry_duration[67:52], entry_value[83:68], zero fill
  input  wire logic [prss_pkg::S_DATA_W-1:0]  s_tdata,
  // command
  input  wire logic                           s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // insert_count[7:0], is_running[8], current_phase[12:9], zero fill
  output logic [prss_pkg::M_DATA_W-1:0]       m_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [prss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [prss_pkg::CFG_DATA_W-1:0] cfg_data
);
  import prss_pkg::*;

  cfg_t     cfg;
  item_t    item;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [7:0] insert_count;
  logic       is_running;
  logic [3:0] current_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_time        <= '0;
      cfg.period            <= 16'd1;
      cfg.source_mode       <= MODE_CONST_PROB;
      cfg.fixed_probability <= '0;
      cfg.fixed_flow        <= '0;
      cfg.phase_count       <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_TIME:  cfg.start_time        <= cfg_data;
        REG_PERIOD:      cfg.period            <= cfg_data[15:0];
        REG_SOURCE_MODE: cfg.source_mode       <= cfg_data[1:0];
        REG_FIXED_PROB:  cfg.fixed_probability <= cfg_data[15:0];
        REG_FIXED_FLOW:  cfg.fixed_flow        <= cfg_data[7:0];
        REG_PHASE_COUNT: cfg.phase_count       <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign item.command        = s_tuser;
  assign item.iteration      = s_tdata[31:0];
  assign item.random_value   = s_tdata[47:32];
  assign item.entry_index    = s_tdata[51:48];
  assign item.entry_duration = s_tdata[67:52];
  assign item.entry_value    = s_tdata[83:68];

  prss_divmod u_divmod (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  prss_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item          (item),
    .s_valid       (s_tvalid),
    .s_ready       (s_tready),
    .m_valid       (m_tvalid),
    .m_ready       (m_tready),
    .insert_count  (insert_count),
    .is_running    (is_running),
    .current_phase (current_phase),
    .div_req       (div_req),
    .div_rsp       (div_rsp)
  );

  assign m_tdata = {3'd0, current_phase, is_running, insert_count};

endmodule
`default_nettype wire

>>> design/prss_divmod.sv
// Bit-serial remainder by the period and start-time compare, one bit per cycle.
`default_nettype none
module prss_divmod (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire prss_pkg::div_req_t  req,
  output prss_pkg::div_rsp_t       rsp
);
  import prss_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [31:0] st;
  logic [15:0] dvs;
  logic [15:0] rem;
  logic        eq;
  logic        gt;

  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic [15:0] rem_next;
  logic        eq_next;
  logic        gt_next;

  always_comb begin
    rem_sh  = {rem, dvd[31]};
    rem_sub = rem_sh - {1'b0, dvs};
    if (rem_sh >= {1'b0, dvs}) begin
      rem_next = rem_sub[15:0];
    end else begin
      rem_next = rem_sh[15:0];
    end
    eq_next = eq & (dvd[31] == st[31]);
    gt_next = gt | (eq & dvd[31] & ~st[31]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      cnt          <= '0;
      rsp.done     <= 1'b0;
      rsp.rem_zero <= 1'b0;
      rsp.ge       <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= req.dividend;
        st   <= req.start_time;
        dvs  <= req.divisor;
        rem  <= '0;
        eq   <= 1'b1;
        gt   <= 1'b0;
      end else if (busy) begin
        dvd <= {dvd[30:0], 1'b0};
        st  <= {st[30:0], 1'b0};
        rem <= rem_next;
        eq  <= eq_next;
        gt  <= gt_next;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy         <= 1'b0;
          rsp.done     <= 1'b1;
          rsp.rem_zero <= (rem_next == 16'd0);
          rsp.ge       <= gt_next | eq_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/prss_ctrl.sv
// Sequencer, phase table, phase state and output register.
`default_nettype none
module prss_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire prss_pkg::cfg_t      cfg,
  input  wire prss_pkg::item_t     item,
  input  wire logic                s_valid,
  output logic                     s_ready,
  output logic                     m_valid,
  input  wire logic                m_ready,
  output logic [7:0]               insert_count,
  output logic                     is_running,
  output logic [3:0]               current_phase,
  output prss_pkg::div_req_t       div_req,
  input  wire prss_pkg::div_rsp_t  div_rsp
);
  import prss_pkg::*;

  state_t      state, state_next;
  logic        cmd;
  logic [15:0] rnd;
  logic        running, running_next;
  logic [PTR_W-1:0] ptr, ptr_next;
  logic [15:0] age, age_next;
  logic [31:0] rd_data;
  logic [31:0] phase_mem [PHASE_SLOTS];

  logic        load_out;
  logic [7:0]  count;
  logic        accept;
  logic        phased;
  logic [CNT_W-1:0] pc_ext;
  logic [CNT_W-1:0] slots;
  logic [CNT_W-1:0] nxt;
  logic [CNT_W-1:0] widx_ext;
  logic [PTR_W+3:0] ptr_ext;
  logic [15:0] val;

  assign s_ready = (state == ST_IDLE);
  assign accept  = s_valid & s_ready;
  assign phased  = (cfg.source_mode == MODE_PHASE_PROB) ||
                   (cfg.source_mode == MODE_PHASE_FLOW);
  assign pc_ext   = CNT_W'(cfg.phase_count);
  assign nxt      = CNT_W'(ptr) + CNT_W'(1);
  assign widx_ext = CNT_W'(item.entry_index);
  assign ptr_ext  = {4'd0, ptr_next};
  assign val      = rd_data[15:0];

  always_comb begin
    if (pc_ext == '0) begin
      slots = CNT_W'(1);
    end else if (pc_ext > CNT_W'(PHASE_SLOTS)) begin
      slots = CNT_W'(PHASE_SLOTS);
    end else begin
      slots = pc_ext;
    end
  end

  assign div_req.start      = accept && (item.command == CMD_TICK);
  assign div_req.dividend   = item.iteration;
  assign div_req.divisor    = (cfg.period == 16'd0) ? 16'd1 : cfg.period;
  assign div_req.start_time = cfg.start_time;

  always_comb begin
    count = 8'd0;
    if ((cmd == CMD_TICK) && running && div_rsp.rem_zero) begin
      unique case (cfg.source_mode)
        MODE_CONST_PROB: count = (rnd < cfg.fixed_probability) ? 8'd1 : 8'd0;
        MODE_PHASE_PROB: count = (rnd < val) ? 8'd1 : 8'd0;
        MODE_CONST_FLOW: count = cfg.fixed_flow;
        MODE_PHASE_FLOW: count = (val[15:8] != 8'd0) ? 8'hFF : val[7:0];
        default:         count = 8'd0;
      endcase
    end
  end

  always_comb begin
    state_next   = state;
    running_next = running;
    ptr_next     = ptr;
    age_next     = age;
    load_out     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_valid) begin
          state_next = (item.command == CMD_WRITE) ? ST_VAL : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) state_next = ST_START;
      end
      ST_START: begin
        if (!running && div_rsp.ge) begin
          running_next = 1'b1;
          ptr_next     = '0;
          age_next     = '0;
        end
        state_next = ST_ADV;
      end
      ST_ADV: begin
        if (running && phased && (age == rd_data[31:16])) begin
          age_next = '0;
          ptr_next = (nxt >= slots) ? '0 : nxt[PTR_W-1:0];
        end
        state_next = ST_VAL;
      end
      ST_VAL: begin
        if (!m_valid || m_ready) begin
          load_out = 1'b1;
          if ((cmd == CMD_TICK) && running) age_next = age + 16'd1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      running <= 1'b0;
      ptr     <= '0;
      age     <= '0;
    end else begin
      state   <= state_next;
      running <= running_next;
      ptr     <= ptr_next;
      age     <= age_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= item.command;
      rnd <= item.random_value;
    end
  end

  // table read follows the pointer as it is being updated
  always_ff @(posedge clk) begin
    if (accept && (item.command == CMD_WRITE) && (widx_ext < CNT_W'(PHASE_SLOTS))) begin
      phase_mem[widx_ext[PTR_W-1:0]] <= {item.entry_duration, item.entry_value};
    end
    rd_data <= phase_mem[ptr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid       <= 1'b0;
      insert_count  <= '0;
      is_running    <= 1'b0;
      current_phase <= '0;
    end else begin
      if (load_out) begin
        m_valid       <= 1'b1;
        insert_count  <= count;
        is_running    <= running_next;
        current_phase <= ptr_ext[3:0];
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/prss_checker.sv
// Port-level assertions for the scheduler, bound to the top level.
`default_nettype none
module prss_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_count_needs_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] == 8'd0) || m_tdata[8])
    else $error("insertions reported while not running");

  a_phase_needs_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[12:9] == 4'd0) || m_tdata[8])
    else $error("phase moved while not running");

  a_run_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> !$fell(m_tdata[8]))
    else $error("running flag dropped without reset");

endmodule

bind phased_rate_source_scheduler_unit prss_port_checks u_prss_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
